// ===== sv/fp32fc_pkg.sv =====
// shared types and constants for the fp32 format converter
`default_nettype none
package fp32fc_pkg;
  typedef enum logic [1:0] {
    TGT_FP32  = 2'd0,
    TGT_BF16  = 2'd1,
    TGT_INT32 = 2'd2,
    TGT_INT8  = 2'd3
  } target_e;

  localparam logic [31:0] AbsMask    = 32'h7FFF_FFFF;
  localparam logic [31:0] ExpInfBits = 32'h7F80_0000;
  localparam logic [31:0] TwoPow31   = 32'h4F00_0000;
  localparam logic [31:0] Int8PosLim = 32'h42FE_0000;
  localparam logic [31:0] Int8NegLim = 32'h4300_0000;
endpackage
`default_nettype wire

// ===== sv/fp32fc_convert.sv =====
// combinational conversion of one fp32 pattern to the target format
`default_nettype none
module fp32fc_convert (
  input  wire logic [31:0]          value_bits_i,
  input  fp32fc_pkg::target_e       target_type_i,
  output logic [31:0]               result_bits_o,
  output logic                      saturated_o
);
  import fp32fc_pkg::*;

  logic [31:0] abs_bits;
  logic        neg;
  logic        is_nan;
  logic [7:0]  exp_f;
  logic [23:0] mant;
  logic [7:0]  sh;
  logic [31:0] shifted;
  logic [31:0] half_bit;
  logic [31:0] rnd_mag;
  logic [31:0] bf_sum;
  logic [15:0] bf16;
  logic [31:0] mag8;
  logic [31:0] neg8;

  assign abs_bits = value_bits_i & AbsMask;
  assign neg      = value_bits_i[31];
  assign is_nan   = abs_bits > ExpInfBits;
  assign exp_f    = abs_bits[30:23];
  assign mant     = {1'b1, abs_bits[22:0]};
  assign sh       = 8'd150 - exp_f;

  // rounded magnitude, half away from zero
  always_comb begin
    shifted  = '0;
    half_bit = '0;
    if (exp_f < 8'd126) begin
      rnd_mag = '0;
    end else if (exp_f >= 8'd150) begin
      rnd_mag = {8'd0, mant} << (exp_f[2:0] - 3'd6);
    end else begin
      shifted  = {8'd0, mant} >> sh[4:0];
      half_bit = ({8'd0, mant} >> (sh[4:0] - 5'd1)) & 32'd1;
      rnd_mag  = shifted + half_bit;
    end
  end

  assign bf_sum = value_bits_i + 32'h0000_7FFF + {31'd0, value_bits_i[16]};

  always_comb begin
    if (is_nan) begin
      bf16 = value_bits_i[31:16] | 16'h0040;
    end else if (abs_bits == ExpInfBits) begin
      bf16 = value_bits_i[31:16];
    end else begin
      bf16 = bf_sum[31:16];
    end
  end

  always_comb begin
    mag8 = rnd_mag;
    if (!neg && abs_bits > Int8PosLim) begin
      mag8 = 32'd127;
    end else if (neg && abs_bits > Int8NegLim) begin
      mag8 = 32'd128;
    end
  end
  assign neg8 = neg ? (32'd0 - mag8) : mag8;

  always_comb begin
    result_bits_o = '0;
    saturated_o   = 1'b0;
    case (target_type_i)
      TGT_FP32: result_bits_o = value_bits_i;
      TGT_BF16: result_bits_o = {16'd0, bf16};
      TGT_INT32: begin
        if (is_nan) begin
          result_bits_o = '0;
        end else if (abs_bits >= TwoPow31) begin
          result_bits_o = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          saturated_o   = !(neg && abs_bits == TwoPow31);
        end else begin
          result_bits_o = neg ? (32'd0 - rnd_mag) : rnd_mag;
        end
      end
      TGT_INT8: begin
        if (!is_nan) begin
          result_bits_o = {24'd0, neg8[7:0]};
          saturated_o   = (!neg && abs_bits > Int8PosLim) || (neg && abs_bits > Int8NegLim);
        end
      end
      default: result_bits_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/fp32_format_converter_unit.sv =====
// top level: registered fp32 to fp32/bf16/int32/int8 converter
// the result of an input transfer is registered and shown on the output register in the next cycle
// throughput: one transfer per cycle while the output is not stalled, set by the single conversion stage
// the input is taken whenever the output register is empty or being drained
// reset: asynchronous active-low, clears the output valid; payload is not reset
`default_nettype none
module fp32_format_converter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_bits_i,
  input  wire logic [1:0]  target_type_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_bits_o,
  output logic             saturated_o
);
  import fp32fc_pkg::*;

  logic        valid_q;
  logic [31:0] res_q, res_d;
  logic        sat_q, sat_d;
  logic        take;

  // stall only when a result waits and the sink is stalled
  assign in_stall_o = valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  fp32fc_convert u_conv (
    .value_bits_i  (value_bits_i),
    .target_type_i (target_e'(target_type_i)),
    .result_bits_o (res_d),
    .saturated_o   (sat_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload capture on each input transfer
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_bits_o = res_q;
  assign saturated_o   = sat_q;
endmodule
`default_nettype wire

// ===== sv/fp32fc_checker.sv =====
// port-level assertions for the converter, bound to the top level
`default_nettype none
module fp32fc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] result_bits_o,
  input wire logic        saturated_o
);
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o) else $error("result missing");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(result_bits_o) && $stable(saturated_o)))
    else $error("stalled result changed");
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("needless stall");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && !in_stall_o) && !(out_valid_o && out_stall_i)) |=> !out_valid_o)
    else $error("invented result");
endmodule

bind fp32_format_converter_unit fp32fc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .result_bits_o(result_bits_o), .saturated_o(saturated_o)
);
`default_nettype wire
